@@ src/iha_pkg.sv @@
`timescale 1ns / 1ps
// Package of the indexed max-heap: sizes, entry type, codes and sequencer states.
// No dependencies; every other file imports it.
package iha_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_BITS = 32;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = SLOT_W + 1;
	localparam int VTX_W    = 11;

	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_DELETE   = 2'd1;
	localparam logic [1:0] ACT_INCREASE = 2'd2;
	localparam logic [1:0] ACT_CLEAR    = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_ABSENT    = 3'd3;
	localparam logic [2:0] ST_NOT_LARGER = 3'd4;

	localparam logic [CNT_W-1:0] ABSENT_SLOT = CNT_W'(CAPACITY);

	typedef struct packed {
		logic [VTX_W-1:0]           vtx;
		logic signed [KEY_BITS-1:0] key;
	} entry_t;

	typedef struct packed {
		logic              heap_we;
		logic [SLOT_W-1:0] heap_waddr;
		entry_t            heap_wdata;
		logic [SLOT_W-1:0] heap_raddr;
		logic              map_we;
		logic [SLOT_W-1:0] map_waddr;
		logic [CNT_W-1:0]  map_wdata;
		logic [SLOT_W-1:0] map_raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BUILD_NEXT,
		S_BUILD_CUR,
		S_DEL_CUR,
		S_SD_LEFT,
		S_SD_LCMP,
		S_SD_RCMP,
		S_INC_MAP,
		S_INC_CMP,
		S_SU_STEP,
		S_SU_CMP,
		S_RESP
	} state_t;

	function automatic logic [SLOT_W-1:0] map_index(input logic [VTX_W-1:0] v);
		logic [VTX_W-1:0] t;
		t = v - VTX_W'(1);
		return t[SLOT_W-1:0];
	endfunction

endpackage

@@ src/iha_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on iha_pkg.
interface iha_in_if;
	import iha_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [VTX_W-1:0]           vertex;
	logic signed [KEY_BITS-1:0] key;
	logic                       last;
	modport source (output valid, action, vertex, key, last, input ready);
	modport sink (input valid, action, vertex, key, last, output ready);
endinterface

interface iha_out_if;
	import iha_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [VTX_W-1:0]           top_vertex;
	logic signed [KEY_BITS-1:0] top_key;
	logic [CNT_W-1:0]           entry_count;
	logic                       is_empty;
	modport source (output valid, status, top_vertex, top_key, entry_count, is_empty,
		input ready);
	modport sink (input valid, status, top_vertex, top_key, entry_count, is_empty,
		output ready);
endinterface

@@ src/iha_store.sv @@
`timescale 1ns / 1ps
// Heap slot memory and vertex position map, one write and one registered read each,
// plus a mirror of slot 0. Depends on iha_pkg.
module iha_store (
	input  logic                     clk,
	input  iha_pkg::mem_req_t        req,
	output iha_pkg::entry_t          heap_rdata,
	output logic [iha_pkg::CNT_W-1:0] map_rdata,
	output iha_pkg::entry_t          top
);
	import iha_pkg::*;

	entry_t           heap_mem [CAPACITY];
	logic [CNT_W-1:0] map_mem  [CAPACITY];
	entry_t           heap_rd_q;
	logic [CNT_W-1:0] map_rd_q;
	entry_t           top_q;

	always_ff @(posedge clk) begin
		if (req.heap_we) begin
			heap_mem[req.heap_waddr] <= req.heap_wdata;
		end
		heap_rd_q <= heap_mem[req.heap_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.map_we) begin
			map_mem[req.map_waddr] <= req.map_wdata;
		end
		map_rd_q <= map_mem[req.map_raddr];
	end

	// keep slot 0 visible without a read port
	always_ff @(posedge clk) begin
		if (req.heap_we && req.heap_waddr == '0) begin
			top_q <= req.heap_wdata;
		end
	end

	assign heap_rdata = heap_rd_q;
	assign map_rdata  = map_rd_q;
	assign top        = top_q;
endmodule

@@ src/iha_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the heap: one shared key comparator stepped through sift-down,
// sift-up and bottom-up build. Depends on iha_pkg and iha_if.
module iha_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	iha_in_if.sink                    in_ch,
	iha_out_if.source                 out_ch,
	output iha_pkg::mem_req_t         req,
	input  iha_pkg::entry_t           heap_rdata,
	input  logic [iha_pkg::CNT_W-1:0] map_rdata,
	input  iha_pkg::entry_t           top
);
	import iha_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, loaded_q;
	logic [SLOT_W-1:0]  i_q, bi_q, bidx_q;
	entry_t             cur_q, best_q, rem_q;
	logic               build_q, removed_q;
	logic [2:0]         status_q;
	logic signed [KEY_BITS-1:0] key_q;

	logic               accept;
	logic               load_ok, del_ok, inc_ok;
	logic [CNT_W:0]     l_idx, r_idx;
	logic               has_left, has_right;
	logic [SLOT_W-1:0]  pidx, ipidx;
	logic signed [KEY_BITS-1:0] cmp_a, cmp_b;
	logic               lt;
	entry_t             fin_e;
	logic [SLOT_W-1:0]  fin_idx;
	logic               fin_move;

	assign accept  = in_ch.valid && in_ch.ready;
	assign load_ok = cnt_q != ABSENT_SLOT && loaded_q != ABSENT_SLOT;
	assign del_ok  = cnt_q != '0;
	assign inc_ok  = in_ch.vertex != '0 && in_ch.vertex <= loaded_q;
	assign l_idx   = {1'b0, i_q, 1'b1};
	assign r_idx   = l_idx + (CNT_W + 1)'(1);
	assign has_left  = l_idx < {1'b0, cnt_q};
	assign has_right = r_idx < {1'b0, cnt_q};
	assign ipidx   = i_q - SLOT_W'(1);
	assign pidx    = ipidx >> 1;

	// shared comparator: operands picked by the step in progress
	always_comb begin
		case (state_q)
			S_SD_RCMP: begin
				cmp_a = best_q.key;
				cmp_b = heap_rdata.key;
			end
			S_INC_CMP: begin
				cmp_a = heap_rdata.key;
				cmp_b = key_q;
			end
			S_SU_CMP: begin
				cmp_a = heap_rdata.key;
				cmp_b = cur_q.key;
			end
			default: begin
				cmp_a = cur_q.key;
				cmp_b = heap_rdata.key;
			end
		endcase
	end
	assign lt = cmp_a < cmp_b;

	// winner of one sift-down level
	always_comb begin
		if (state_q == S_SD_RCMP) begin
			fin_e   = lt ? heap_rdata : best_q;
			fin_idx = lt ? r_idx[SLOT_W-1:0] : bidx_q;
		end else begin
			fin_e   = lt ? heap_rdata : cur_q;
			fin_idx = lt ? l_idx[SLOT_W-1:0] : i_q;
		end
	end
	assign fin_move = fin_idx != i_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_ch.action)
						ACT_LOAD:     state_d = (load_ok && in_ch.last) ? S_BUILD_NEXT : S_RESP;
						ACT_DELETE:   state_d = (cnt_q > CNT_W'(1)) ? S_DEL_CUR : S_RESP;
						ACT_INCREASE: state_d = inc_ok ? S_INC_MAP : S_RESP;
						default:      state_d = S_RESP;
					endcase
				end
			end
			S_BUILD_NEXT: state_d = (bi_q == '0) ? S_RESP : S_BUILD_CUR;
			S_BUILD_CUR:  state_d = S_SD_LEFT;
			S_DEL_CUR:    state_d = S_SD_LEFT;
			S_SD_LEFT: begin
				if (has_left) begin
					state_d = S_SD_LCMP;
				end else begin
					state_d = build_q ? S_BUILD_NEXT : S_RESP;
				end
			end
			S_SD_LCMP, S_SD_RCMP: begin
				if (state_q == S_SD_LCMP && has_right) begin
					state_d = S_SD_RCMP;
				end else if (fin_move) begin
					state_d = S_SD_LEFT;
				end else begin
					state_d = build_q ? S_BUILD_NEXT : S_RESP;
				end
			end
			S_INC_MAP: state_d = (map_rdata >= cnt_q) ? S_RESP : S_INC_CMP;
			S_INC_CMP: state_d = lt ? S_SU_STEP : S_RESP;
			S_SU_STEP: state_d = (i_q == '0) ? S_RESP : S_SU_CMP;
			S_SU_CMP:  state_d = lt ? S_SU_STEP : S_RESP;
			S_RESP:    state_d = out_ch.ready ? S_IDLE : S_RESP;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_ch.action == ACT_LOAD && load_ok) begin
					req.heap_we    = 1'b1;
					req.heap_waddr = cnt_q[SLOT_W-1:0];
					req.heap_wdata = '{vtx: loaded_q + CNT_W'(1), key: in_ch.key};
					req.map_we     = 1'b1;
					req.map_waddr  = loaded_q[SLOT_W-1:0];
					req.map_wdata  = cnt_q;
				end
				if (accept && in_ch.action == ACT_DELETE && del_ok) begin
					req.map_we     = 1'b1;
					req.map_waddr  = map_index(top.vtx);
					req.map_wdata  = ABSENT_SLOT;
				end
				req.heap_raddr = SLOT_W'(cnt_q - CNT_W'(1));
				req.map_raddr  = map_index(in_ch.vertex);
			end
			S_BUILD_NEXT: req.heap_raddr = bi_q - SLOT_W'(1);
			S_SD_LEFT: begin
				req.heap_raddr = l_idx[SLOT_W-1:0];
				if (!has_left) begin
					req.heap_we    = 1'b1;
					req.heap_waddr = i_q;
					req.heap_wdata = cur_q;
					req.map_we     = 1'b1;
					req.map_waddr  = map_index(cur_q.vtx);
					req.map_wdata  = {1'b0, i_q};
				end
			end
			S_SD_LCMP, S_SD_RCMP: begin
				req.heap_raddr = r_idx[SLOT_W-1:0];
				if (!(state_q == S_SD_LCMP && has_right)) begin
					req.heap_we    = 1'b1;
					req.heap_waddr = i_q;
					req.heap_wdata = fin_move ? fin_e : cur_q;
					req.map_we     = 1'b1;
					req.map_waddr  = map_index(fin_move ? fin_e.vtx : cur_q.vtx);
					req.map_wdata  = {1'b0, i_q};
				end
			end
			S_INC_MAP: req.heap_raddr = map_rdata[SLOT_W-1:0];
			S_SU_STEP: begin
				req.heap_raddr = pidx;
				if (i_q == '0) begin
					req.heap_we    = 1'b1;
					req.heap_waddr = i_q;
					req.heap_wdata = cur_q;
					req.map_we     = 1'b1;
					req.map_waddr  = map_index(cur_q.vtx);
					req.map_wdata  = {1'b0, i_q};
				end
			end
			S_SU_CMP: begin
				req.heap_we    = 1'b1;
				req.heap_waddr = i_q;
				req.heap_wdata = lt ? heap_rdata : cur_q;
				req.map_we     = 1'b1;
				req.map_waddr  = map_index(lt ? heap_rdata.vtx : cur_q.vtx);
				req.map_wdata  = {1'b0, i_q};
			end
			default: req = '0;
		endcase
	end

	assign in_ch.ready        = state_q == S_IDLE;
	assign out_ch.valid       = state_q == S_RESP;
	assign out_ch.status      = status_q;
	assign out_ch.top_vertex  = removed_q ? rem_q.vtx : (cnt_q != '0 ? top.vtx : '0);
	assign out_ch.top_key     = removed_q ? rem_q.key : (cnt_q != '0 ? top.key : '0);
	assign out_ch.entry_count = cnt_q;
	assign out_ch.is_empty    = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			loaded_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && accept) begin
				case (in_ch.action)
					ACT_LOAD: begin
						if (load_ok) begin
							cnt_q    <= cnt_q + CNT_W'(1);
							loaded_q <= loaded_q + CNT_W'(1);
						end
					end
					ACT_DELETE: begin
						if (del_ok) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
					ACT_CLEAR: begin
						cnt_q    <= '0;
						loaded_q <= '0;
					end
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					removed_q <= 1'b0;
					status_q  <= ST_OK;
					key_q     <= in_ch.key;
					cur_q     <= '{vtx: in_ch.vertex, key: in_ch.key};
					i_q       <= '0;
					build_q   <= 1'b0;
					rem_q     <= top;
					case (in_ch.action)
						ACT_LOAD: begin
							if (!load_ok) begin
								status_q <= ST_FULL;
							end
							build_q <= 1'b1;
							bi_q    <= SLOT_W'((cnt_q + CNT_W'(1)) >> 1);
						end
						ACT_DELETE: begin
							if (del_ok) begin
								removed_q <= 1'b1;
							end else begin
								status_q <= ST_EMPTY;
							end
						end
						ACT_INCREASE: begin
							if (!inc_ok) begin
								status_q <= ST_ABSENT;
							end
						end
						default: status_q <= ST_OK;
					endcase
				end
			end
			S_BUILD_NEXT: begin
				if (bi_q != '0) begin
					i_q  <= bi_q - SLOT_W'(1);
					bi_q <= bi_q - SLOT_W'(1);
				end
			end
			S_BUILD_CUR, S_DEL_CUR: cur_q <= heap_rdata;
			S_SD_LCMP, S_SD_RCMP: begin
				if (state_q == S_SD_LCMP && has_right) begin
					best_q <= fin_e;
					bidx_q <= fin_idx;
				end else if (fin_move) begin
					i_q <= fin_idx;
				end
			end
			S_INC_MAP: begin
				if (map_rdata >= cnt_q) begin
					status_q <= ST_ABSENT;
				end
				i_q <= map_rdata[SLOT_W-1:0];
			end
			S_INC_CMP: begin
				if (!lt) begin
					status_q <= ST_NOT_LARGER;
				end
			end
			S_SU_CMP: begin
				if (lt) begin
					i_q <= pidx;
				end
			end
			default: i_q <= i_q;
		endcase
	end
endmodule

@@ src/indexed_max_heap.sv @@
`timescale 1ns / 1ps
// Indexed binary max-heap of (vertex, key) entries with a vertex-to-slot map.
// A delete sifts the last entry down from the root and an increase sifts the entry up;
// a last load runs a Floyd build, sifting down each parent from the last to the root.
// Throughput: one item at a time, set by the single heap read port and comparator.
// Reset (arst_n low): empty heap, vertex numbering restarted; memories hold junk.
// Depends on iha_pkg, iha_if, iha_store and iha_ctrl.
module indexed_max_heap (
	input logic       clk,
	input logic       arst_n,
	iha_in_if.sink    in_ch,
	iha_out_if.source out_ch
);
	import iha_pkg::*;

	mem_req_t         req;
	entry_t           heap_rdata;
	logic [CNT_W-1:0] map_rdata;
	entry_t           top;

	// sequencer: decode the item, walk the tree, build the result
	iha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.req        (req),
		.heap_rdata (heap_rdata),
		.map_rdata  (map_rdata),
		.top        (top)
	);

	// slot memory, position map and the mirrored top entry
	iha_store u_store (
		.clk        (clk),
		.req        (req),
		.heap_rdata (heap_rdata),
		.map_rdata  (map_rdata),
		.top        (top)
	);
endmodule

@@ src/iha_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the heap block, bound to its top level.
// Depends on iha_pkg.
module iha_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [iha_pkg::CNT_W-1:0] entry_count,
	input logic                      is_empty
);
	import iha_pkg::*;

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("item taken while busy");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("not idle after result");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (entry_count == '0)) else $error("empty flag mismatch");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind indexed_max_heap iha_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.entry_count (out_ch.entry_count),
	.is_empty    (out_ch.is_empty)
);

@@ verif/indexed_max_heap_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for indexed_max_heap: random and directed heap operations with a
// behavioral heap predictor. Depends on iha_pkg, iha_if and the block's RTL.
module indexed_max_heap_test;
	import iha_pkg::*;

	typedef struct {
		logic [1:0]                 action;
		logic [VTX_W-1:0]           vertex;
		logic signed [KEY_BITS-1:0] key;
		logic                       last;
	} heap_op_t;

	typedef struct {
		logic [2:0]                 status;
		logic [VTX_W-1:0]           top_vertex;
		logic signed [KEY_BITS-1:0] top_key;
		logic [CNT_W-1:0]           entry_count;
		logic                       is_empty;
	} heap_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iha_in_if  in_ch ();
	iha_out_if out_ch ();

	indexed_max_heap u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: slots, vertex-to-slot map, counts.
	logic [VTX_W-1:0]           mdl_vtx [CAPACITY];
	logic signed [KEY_BITS-1:0] mdl_key [CAPACITY];
	int                         mdl_pos [CAPACITY];
	int                         mdl_count;
	int                         mdl_loaded;

	heap_op_t     pending_ops[$];
	heap_report_t expected_reports[$];
	int           errors;
	int           ops_sent;
	int           reports_seen;
	int           stat_hist [5];
	bit           stim_done;
	bit           hold_sender;

	function automatic void swap_slot(int a, int b);
		logic [VTX_W-1:0]           tv;
		logic signed [KEY_BITS-1:0] tk;
		tv = mdl_vtx[a]; tk = mdl_key[a];
		mdl_vtx[a] = mdl_vtx[b]; mdl_key[a] = mdl_key[b];
		mdl_vtx[b] = tv; mdl_key[b] = tk;
		mdl_pos[mdl_vtx[a] - 1] = a;
		mdl_pos[mdl_vtx[b] - 1] = b;
	endfunction

	function automatic void sink_slot(int i);
		int best;
		forever begin
			best = i;
			if (2*i+1 < mdl_count && mdl_key[best] < mdl_key[2*i+1]) best = 2*i+1;
			if (2*i+2 < mdl_count && mdl_key[best] < mdl_key[2*i+2]) best = 2*i+2;
			if (best == i) return;
			swap_slot(i, best);
			i = best;
		end
	endfunction

	function automatic void float_slot(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!(mdl_key[p] < mdl_key[i])) return;
			swap_slot(i, p);
			i = p;
		end
	endfunction

	// Apply one operation to the predictor and return the report it must produce.
	function automatic heap_report_t apply_heap_op(heap_op_t op);
		heap_report_t r;
		bit removed;
		int s;
		r = '{ST_OK, '0, '0, '0, 1'b0};
		removed = 0;
		case (op.action)
			ACT_LOAD: begin
				if (mdl_count >= CAPACITY || mdl_loaded >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					mdl_vtx[mdl_count] = VTX_W'(mdl_loaded + 1);
					mdl_key[mdl_count] = op.key;
					mdl_pos[mdl_loaded] = mdl_count;
					mdl_loaded++;
					mdl_count++;
					if (op.last)
						for (int i = mdl_count/2 - 1; i >= 0; i--) sink_slot(i);
				end
			end
			ACT_DELETE: begin
				if (mdl_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.top_vertex = mdl_vtx[0];
					r.top_key = mdl_key[0];
					removed = 1;
					mdl_pos[mdl_vtx[0] - 1] = CAPACITY;
					mdl_count--;
					if (mdl_count > 0) begin
						mdl_vtx[0] = mdl_vtx[mdl_count];
						mdl_key[0] = mdl_key[mdl_count];
						mdl_pos[mdl_vtx[0] - 1] = 0;
						sink_slot(0);
					end
				end
			end
			ACT_INCREASE: begin
				if (op.vertex < 1 || op.vertex > mdl_loaded || op.vertex > CAPACITY ||
						mdl_pos[op.vertex - 1] >= mdl_count) begin
					r.status = ST_ABSENT;
				end else begin
					s = mdl_pos[op.vertex - 1];
					if (!(mdl_key[s] < op.key)) begin
						r.status = ST_NOT_LARGER;
					end else begin
						mdl_key[s] = op.key;
						float_slot(s);
					end
				end
			end
			default: begin
				mdl_count = 0;
				mdl_loaded = 0;
			end
		endcase
		if (!removed && mdl_count > 0) begin
			r.top_vertex = mdl_vtx[0];
			r.top_key = mdl_key[0];
		end
		r.entry_count = CNT_W'(mdl_count);
		r.is_empty = (mdl_count == 0);
		return r;
	endfunction

	// Stimulus shadow: tracks count and loaded vertices so increases hit real vertices.
	int gen_count;
	int gen_loaded;

	task automatic push_op(logic [1:0] a, int v, logic signed [KEY_BITS-1:0] k, bit l);
		heap_op_t op;
		op.action = a; op.vertex = VTX_W'(v); op.key = k; op.last = l;
		pending_ops.push_back(op);
		case (a)
			ACT_LOAD: if (gen_count < CAPACITY && gen_loaded < CAPACITY) begin
				gen_count++; gen_loaded++;
			end
			ACT_DELETE: if (gen_count > 0) gen_count--;
			ACT_CLEAR: begin gen_count = 0; gen_loaded = 0; end
			default: ;
		endcase
	endtask

	function automatic logic signed [KEY_BITS-1:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return KEY_BITS'($urandom_range(0, 15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Driver: change inputs at the falling edge, hold until accepted.
	int in_gap;
	int in_mark;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= ACT_CLEAR;
			in_ch.vertex <= '0;
			in_ch.key <= '0;
			in_ch.last <= 1'b0;
			in_gap <= 0;
			in_mark <= 0;
		end else if (in_ch.valid && ops_sent == in_mark) begin
			// hold the item until the block takes it
		end else if (in_gap > 0) begin
			in_ch.valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_ops.size() > 0 && !hold_sender) begin
			heap_op_t op;
			op = pending_ops.pop_front();
			in_ch.valid <= 1'b1;
			in_ch.action <= op.action;
			in_ch.vertex <= op.vertex;
			in_ch.key <= op.key;
			in_ch.last <= op.last;
			in_mark <= ops_sent;
			in_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Predict on acceptance at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			heap_op_t op;
			op.action = in_ch.action; op.vertex = in_ch.vertex;
			op.key = in_ch.key; op.last = in_ch.last;
			expected_reports.push_back(apply_heap_op(op));
			ops_sent++;
		end
	end

	// Monitor: compare each accepted report against the oldest prediction.
	int out_stall;
	int out_draw;
	int seen_mark;
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			heap_report_t e;
			reports_seen++;
			if (expected_reports.size() == 0) begin
				$error("unexpected report, status %0d", out_ch.status);
				errors++;
			end else begin
				e = expected_reports.pop_front();
				if (e.status <= ST_NOT_LARGER) stat_hist[e.status]++;
				if (out_ch.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, out_ch.status);
					errors++;
				end
				if (out_ch.top_vertex !== e.top_vertex) begin
					$error("top_vertex: expected %0d, got %0d", e.top_vertex,
						out_ch.top_vertex);
					errors++;
				end
				if (out_ch.top_key !== e.top_key) begin
					$error("top_key: expected %0d, got %0d", e.top_key, out_ch.top_key);
					errors++;
				end
				if (out_ch.entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count,
						out_ch.entry_count);
					errors++;
				end
				if (out_ch.is_empty !== e.is_empty) begin
					$error("is_empty: expected %0d, got %0d", e.is_empty, out_ch.is_empty);
					errors++;
				end
			end
		end
	end

	// Result-side backpressure: after each report draw the wait for the next one,
	// counted in cycles while a report is offered; sometimes none at all.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b1;
			out_stall <= 0;
			seen_mark <= 0;
		end else if (reports_seen != seen_mark) begin
			seen_mark <= reports_seen;
			out_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
			out_stall <= out_draw;
			out_ch.ready <= (out_draw == 0);
		end else if (out_stall > 0) begin
			if (out_ch.valid) out_stall <= out_stall - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Stimulus
	initial begin
		int n, v;
		errors = 0; ops_sent = 0; reports_seen = 0;
		stim_done = 0; hold_sender = 1;
		gen_count = 0; gen_loaded = 0;
		mdl_count = 0; mdl_loaded = 0;
		foreach (stat_hist[i]) stat_hist[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: empty delete, increase on empty, extreme keys, ties, absent vertices.
		push_op(ACT_DELETE, 2047, 32'sh7fffffff, 1);
		push_op(ACT_INCREASE, 1, 32'sh7fffffff, 1);
		push_op(ACT_LOAD, 0, 32'sh80000000, 0);
		push_op(ACT_LOAD, 0, 32'sh7fffffff, 0);
		push_op(ACT_LOAD, 0, 5, 0);
		push_op(ACT_LOAD, 0, 5, 0);
		push_op(ACT_INCREASE, 1, 32'sh7fffffff, 0);  // unordered heap
		push_op(ACT_LOAD, 2047, 5, 1);               // build with ties
		push_op(ACT_INCREASE, 0, 9, 0);              // vertex zero
		push_op(ACT_INCREASE, 6, 9, 0);              // above loaded count
		push_op(ACT_INCREASE, 2047, 9, 0);
		push_op(ACT_INCREASE, 3, 5, 0);              // equal key
		push_op(ACT_INCREASE, 3, 4, 0);              // smaller key
		push_op(ACT_INCREASE, 3, 6, 0);
		push_op(ACT_DELETE, 0, 0, 0);
		push_op(ACT_INCREASE, 2, 32'sh7fffffff, 0);  // vertex now on top, equal key
		push_op(ACT_LOAD, 0, -1, 0);                 // load after build
		push_op(ACT_DELETE, 0, 0, 0);
		push_op(ACT_CLEAR, 1024, 32'sh7fffffff, 1);
		push_op(ACT_CLEAR, 0, 0, 0);
		hold_sender = 0;

		// Random: load runs mostly ending in a build, mixed with deletes, increases, loads, clears.
		while (ops_sent + pending_ops.size() < 460) begin
			if (pending_ops.size() > 40) begin
				@(posedge clk);
				continue;
			end
			case ($urandom_range(0, 9))
				0: push_op(ACT_CLEAR, $urandom_range(0, 2047), rand_key(), $urandom_range(0, 1));
				1, 2, 3: begin
					n = $urandom_range(1, 12);
					for (int i = 0; i < n; i++) push_op(ACT_LOAD, $urandom_range(0, 2047),
						rand_key(), (i == n - 1) ? ($urandom_range(0, 3) != 0) : 1'b0);
				end
				4, 5: push_op(ACT_DELETE, $urandom_range(0, 2047), rand_key(),
					$urandom_range(0, 1));
				6, 7, 8: begin
					v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
						: $urandom_range(1, gen_loaded + 1);
					push_op(ACT_INCREASE, v, rand_key(), $urandom_range(0, 1));
				end
				default: push_op(ACT_LOAD, $urandom_range(0, 2047), rand_key(),
					$urandom_range(0, 1));
			endcase
		end

		// Let the heap drain, then fill it to capacity for the full-heap case.
		wait (pending_ops.size() == 0 && expected_reports.size() == 0 && !in_ch.valid);
		hold_sender = 1;
		repeat (100) @(posedge clk);
		push_op(ACT_CLEAR, 0, 0, 0);
		for (int i = 0; i < CAPACITY; i++)
			push_op(ACT_LOAD, i, $urandom, i == CAPACITY - 1);
		push_op(ACT_LOAD, 0, 1, 1);                  // full heap with last set
		for (int i = 0; i < 60; i++)
			push_op(($urandom_range(0, 1) == 0) ? ACT_DELETE : ACT_INCREASE,
				$urandom_range(1, 1024), $urandom, 0);
		push_op(ACT_LOAD, 0, 1, 0);                  // loaded count still full
		push_op(ACT_CLEAR, 0, 0, 0);
		hold_sender = 0;

		wait (pending_ops.size() == 0 && !in_ch.valid);
		wait (expected_reports.size() == 0);
		repeat (100) @(posedge clk);
		$display("Ran %0d items, %0d reports: ok %0d, empty %0d, full %0d, absent %0d,",
			ops_sent, reports_seen, stat_hist[0], stat_hist[1], stat_hist[2],
			stat_hist[3]);
		$display("not larger %0d; includes a full 1024-entry build and capacity checks.",
			stat_hist[4]);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: allow plenty of time for a full build.
	initial begin
		#200ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
